/* design/rv32i_rtype_execute_core_defines.svh */
// Assertion macros used by the checker file of the execute core.
`ifndef RV32I_RTYPE_EXECUTE_CORE_DEFINES_SVH
`define RV32I_RTYPE_EXECUTE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVEXE_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("execute core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RVEXE_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("execute core assertion failed");

`endif

/* design/rvexe_pkg.sv */
`default_nettype none

package rvexe_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned IDX_W = 5;

  typedef enum logic [1:0] {
    REQ_EXEC  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_EXEC  = 2'd0,
    ST_NOP   = 2'd1,
    ST_WRITE = 2'd2,
    ST_READ  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    F3_ADD_SUB = 3'd0,
    F3_SLL     = 3'd1,
    F3_SLT     = 3'd2,
    F3_SLTU    = 3'd3,
    F3_XOR     = 3'd4,
    F3_SRL_SRA = 3'd5,
    F3_OR      = 3'd6,
    F3_AND     = 3'd7
  } funct3_e;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef struct packed {
    funct3_e    funct3;
    logic [6:0] funct7;
  } alu_op_t;

endpackage

`default_nettype wire

/* design/rvexe_ram.sv */
`default_nettype none

module rvexe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr0_i,
  input  wire logic [AddrW-1:0] raddr1_i,
  output logic      [Width-1:0] rdata0_o,
  output logic      [Width-1:0] rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

`default_nettype wire

/* design/rvexe_alu.sv */
`default_nettype none

module rvexe_alu
  import rvexe_pkg::*;
(
  input  wire alu_op_t          op_i,
  input  wire logic [XLEN-1:0]  a_i,
  input  wire logic [XLEN-1:0]  b_i,
  output logic      [XLEN-1:0]  result_o,
  output logic                  ok_o
);

  logic [4:0] shamt;

  assign shamt = b_i[4:0];

  always_comb begin
    result_o = '0;
    ok_o     = 1'b1;
    unique case (op_i.funct3)
      F3_ADD_SUB: begin
        if (op_i.funct7 == F7_BASE) begin
          result_o = a_i + b_i;
        end else if (op_i.funct7 == F7_ALT) begin
          result_o = a_i - b_i;
        end else begin
          ok_o = 1'b0;
        end
      end
      F3_SLL:  result_o = a_i << shamt;
      F3_SLT:  result_o = {{(XLEN-1){1'b0}}, ($signed(a_i) < $signed(b_i))};
      F3_SLTU: result_o = {{(XLEN-1){1'b0}}, (a_i < b_i)};
      F3_XOR:  result_o = a_i ^ b_i;
      F3_SRL_SRA: begin
        if (op_i.funct7 == F7_BASE) begin
          result_o = a_i >> shamt;
        end else begin
          result_o = $unsigned($signed(a_i) >>> shamt);
        end
      end
      F3_OR:   result_o = a_i | b_i;
      F3_AND:  result_o = a_i & b_i;
      default: result_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/rv32i_rtype_execute_core.sv */
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i/in_stall_o   req_type, instr_word, access_index, write_value
// out      source     out_valid_o/out_stall_i out_value, out_index, out_status
//
// One transaction per cycle unless in_stall_o is high; results are registered at the output.
// The input register stage reads both source registers from the dual-read register RAM.
// The output stage runs the ALU, writes the register file and loads the output register.
// Reset clears per-register valid flags at once, so all registers read as zero.
// A stalled output holds the pipeline; once stage one is occupied, the input stalls too.
`default_nettype none

module rv32i_rtype_execute_core
  import rvexe_pkg::*;
#(
  parameter int unsigned REG_COUNT = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              req_type_i,
  input  wire logic [XLEN-1:0]         instr_word_i,
  input  wire logic [IDX_W-1:0]        access_index_i,
  input  wire logic signed [XLEN-1:0]  write_value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [XLEN-1:0]       out_value_o,
  output logic [IDX_W-1:0]             out_index_o,
  output logic [1:0]                   out_status_o
);

  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [IDX_W:0] RegLimit = (IDX_W+1)'(REG_COUNT);

  typedef struct packed {
    req_type_e        req;
    alu_op_t          op;
    logic [IDX_W-1:0] rd;
    logic [IDX_W-1:0] src1;
    logic [IDX_W-1:0] src2;
    logic [XLEN-1:0]  wval;
  } stage_t;

  logic             in_acc;
  logic             out_move;
  logic             s1_fire;
  logic             s1_v_q, s1_v_d;
  stage_t           s1_q;
  stage_t           s1_d;
  logic [AW-1:0]    rd_addr0, rd_addr1;
  logic [XLEN-1:0]  rdata0, rdata1;
  logic [REG_COUNT-1:0] reg_v_q;
  logic             byp_v_q;
  logic [IDX_W-1:0] byp_idx_q;
  logic [XLEN-1:0]  byp_val_q;
  logic [XLEN-1:0]  src1_val, src2_val;
  logic [XLEN-1:0]  alu_res;
  logic             alu_ok;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [XLEN-1:0]  wr_val;
  logic [AW-1:0]    wr_addr;
  logic             out_v_q;
  logic [XLEN-1:0]  out_value_q, out_value_d;
  logic [IDX_W-1:0] out_index_q, out_index_d;
  status_e          out_status_q, out_status_d;

  function automatic logic idx_ok(logic [IDX_W-1:0] idx);
    return (idx != '0) && ({1'b0, idx} < RegLimit);
  endfunction

  function automatic logic [AW-1:0] idx_addr(logic [IDX_W-1:0] idx);
    return idx_ok(idx) ? idx[AW-1:0] : '0;
  endfunction

  assign out_move   = !out_v_q || !out_stall_i;
  assign s1_fire    = s1_v_q && out_move;
  assign in_stall_o = s1_v_q && !out_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_d.req         = req_type_e'(req_type_i);
    s1_d.op.funct3   = funct3_e'(instr_word_i[14:12]);
    s1_d.op.funct7   = instr_word_i[31:25];
    s1_d.rd          = instr_word_i[11:7];
    s1_d.src1        = (req_type_i == REQ_READ) ? access_index_i : instr_word_i[19:15];
    s1_d.src2        = instr_word_i[24:20];
    s1_d.wval        = $unsigned(write_value_i);
    if (req_type_i == REQ_WRITE) begin
      s1_d.rd = access_index_i;
    end
  end

  always_comb begin
    s1_v_d = s1_v_q && !s1_fire;
    if (in_acc && (req_type_i == REQ_EXEC || req_type_i == REQ_WRITE ||
                   req_type_i == REQ_READ)) begin
      s1_v_d = 1'b1;
    end
  end

  assign rd_addr0 = idx_addr(s1_d.src1);
  assign rd_addr1 = idx_addr(s1_d.src2);

  rvexe_ram #(
    .Width (XLEN),
    .Depth (REG_COUNT)
  ) u_regs (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (wr_addr),
    .wdata_i  (wr_val),
    .re_i     (in_acc),
    .raddr0_i (rd_addr0),
    .raddr1_i (rd_addr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  always_comb begin
    src1_val = '0;
    if (idx_ok(s1_q.src1)) begin
      if (byp_v_q && byp_idx_q == s1_q.src1) begin
        src1_val = byp_val_q;
      end else if (reg_v_q[idx_addr(s1_q.src1)]) begin
        src1_val = rdata0;
      end
    end
    src2_val = '0;
    if (idx_ok(s1_q.src2)) begin
      if (byp_v_q && byp_idx_q == s1_q.src2) begin
        src2_val = byp_val_q;
      end else if (reg_v_q[idx_addr(s1_q.src2)]) begin
        src2_val = rdata1;
      end
    end
  end

  rvexe_alu u_alu (
    .op_i     (s1_q.op),
    .a_i      (src1_val),
    .b_i      (src2_val),
    .result_o (alu_res),
    .ok_o     (alu_ok)
  );

  always_comb begin
    out_index_d  = s1_q.rd;
    out_value_d  = alu_res;
    out_status_d = ST_EXEC;
    wr_val       = alu_res;
    wr_idx       = s1_q.rd;
    wr_en        = 1'b0;
    unique case (s1_q.req)
      REQ_EXEC: begin
        if (alu_ok) begin
          wr_en = s1_fire;
        end else begin
          out_value_d  = '0;
          out_status_d = ST_NOP;
        end
      end
      REQ_WRITE: begin
        out_value_d  = s1_q.wval;
        out_status_d = ST_WRITE;
        wr_val       = s1_q.wval;
        wr_en        = s1_fire;
      end
      REQ_READ: begin
        out_index_d  = s1_q.src1;
        out_value_d  = src1_val;
        out_status_d = ST_READ;
      end
      default: begin
        out_status_d = ST_EXEC;
      end
    endcase
    wr_en   = wr_en && idx_ok(wr_idx);
    wr_addr = idx_addr(wr_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      byp_v_q <= 1'b0;
      reg_v_q <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      if (out_move) begin
        out_v_q <= s1_v_q;
      end
      if (wr_en) begin
        byp_v_q          <= 1'b1;
        reg_v_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_fire) begin
      out_value_q  <= out_value_d;
      out_index_q  <= out_index_d;
      out_status_q <= out_status_d;
    end
    if (wr_en) begin
      byp_idx_q <= wr_idx;
      byp_val_q <= wr_val;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_value_o  = $signed(out_value_q);
  assign out_index_o  = out_index_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

/* design/rvexe_checker.sv */
`default_nettype none
`include "rv32i_rtype_execute_core_defines.svh"

module rvexe_checker
  import rvexe_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic signed [XLEN-1:0]  out_value_o,
  input wire logic [IDX_W-1:0]        out_index_o,
  input wire logic [1:0]              out_status_o
);

  logic [XLEN+IDX_W+1:0] out_word;
  logic                  out_held;
  logic                  out_nop;
  logic                  out_x0_read;

  assign out_word    = {out_value_o, out_index_o, out_status_o};
  assign out_held    = out_valid_o && out_stall_i;
  assign out_nop     = out_valid_o && (out_status_o == ST_NOP);
  assign out_x0_read = out_valid_o && (out_status_o == ST_READ) && (out_index_o == '0);

  `RVEXE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_word))
  `RVEXE_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_held)
  `RVEXE_ASSERT_IMP(a_nop_zero, clk_i, rst_ni, out_nop, out_value_o == '0)
  `RVEXE_ASSERT_IMP(a_x0_zero, clk_i, rst_ni, out_x0_read, out_value_o == '0)
  `RVEXE_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i)

endmodule

bind rv32i_rtype_execute_core rvexe_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_value_o  (out_value_o),
  .out_index_o  (out_index_o),
  .out_status_o (out_status_o)
);

`default_nettype wire
